// ===== rtl/core/lsbod_pkg.sv =====
`timescale 1ns / 1ps
package lsbod_pkg;

  localparam int BEAM_COUNT         = 180;
  localparam int TRIG_FRACTION_BITS = 15;

  localparam int RANGE_W   = 20;
  localparam int TOL_W     = 16;
  localparam int ANGLE_W   = 8;
  localparam int CFG_W     = 20;
  localparam int TRIG_W    = TRIG_FRACTION_BITS + 1;
  localparam int PROD_W    = RANGE_W + TRIG_W;
  localparam int CNT_W     = $clog2(BEAM_COUNT + 1);
  localparam int ROM_IDX_W = $clog2(BEAM_COUNT);

  typedef logic [RANGE_W-1:0]   range_t;
  typedef logic [TOL_W-1:0]     tol_t;
  typedef logic [ANGLE_W-1:0]   angle_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;
  typedef logic [TRIG_W-1:0]    trig_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ROM_IDX_W-1:0] rom_idx_t;

  localparam range_t NO_HIT_RANGE = 20'd999999;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [1:0] {
    REG_BOX_LENGTH = 2'd0,
    REG_BOX_WIDTH  = 2'd1,
    REG_LOWER_TOL  = 2'd2,
    REG_UPPER_TOL  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    range_t box_length_mm;
    range_t box_width_mm;
    tol_t   lower_tolerance_mm;
    tol_t   upper_tolerance_mm;
  } cfg_t;

  typedef struct packed {
    range_t range_mm;
    logic   scan_end;
  } in_word_t;

  typedef struct packed {
    range_t nearest_range_mm;
    angle_t nearest_angle_deg;
    range_t ahead_distance_mm;
    logic   obstacle;
  } out_word_t;

  // end-of-scan summary handed from the judging stage to the projection stage
  typedef struct packed {
    range_t best_range;
    angle_t best_angle;
    logic   hit;
  } scan_sum_t;

  typedef trig_t trig_rom_t [BEAM_COUNT];

  // sin of k degrees (0..90) with 30 fraction bits, eight-term series
  function automatic logic [63:0] sine_q30(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
    if (sum > (64'd1 << 30)) begin
      sum = 64'd1 << 30;
    end
    return sum;
  endfunction

  function automatic trig_t sine_mag(input int unsigned k);
    int unsigned a;
    logic [63:0] s;
    a = k % 180;
    if (a > 90) begin
      a = 180 - a;
    end
    s = sine_q30(a);
    s = (s + (64'd1 << (29 - TRIG_FRACTION_BITS))) >> (30 - TRIG_FRACTION_BITS);
    return s[TRIG_W-1:0];
  endfunction

  function automatic trig_rom_t build_rom(input logic cos_sel);
    trig_rom_t rom;
    for (int unsigned k = 0; k < BEAM_COUNT; k++) begin
      rom[k] = sine_mag(cos_sel ? k + 90 : k);
    end
    return rom;
  endfunction

  localparam trig_rom_t SIN_ROM = build_rom(1'b0);
  localparam trig_rom_t COS_ROM = build_rom(1'b1);

endpackage

// ===== rtl/core/lsbod_judge.sv =====
`timescale 1ns / 1ps
module lsbod_judge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lsbod_pkg::in_word_t  in_data,
  input  lsbod_pkg::cfg_t      cfg,
  output logic                 sum_valid,
  input  logic                 sum_ready,
  output lsbod_pkg::scan_sum_t sum_data
);

  logic                hold_valid;
  lsbod_pkg::in_word_t hold;

  lsbod_pkg::cnt_t   beam_count;
  lsbod_pkg::range_t prev_sample;
  lsbod_pkg::range_t prev_prev_sample;
  lsbod_pkg::range_t best_range;
  lsbod_pkg::angle_t best_angle;
  logic              hit_flag;

  lsbod_pkg::range_t best_range_next;
  lsbod_pkg::angle_t best_angle_next;
  logic              hit_flag_next;

  logic                adv;
  logic                fire;
  logic                counting;
  logic                judged;
  lsbod_pkg::rom_idx_t mid_idx;
  lsbod_pkg::prod_t    fwd;
  lsbod_pkg::prod_t    side;
  lsbod_pkg::prod_t    len_lim;
  lsbod_pkg::prod_t    wid_lim;
  logic                box_hit;
  logic                agree_back;
  logic                agree_fwd;

  function automatic logic agrees(input lsbod_pkg::range_t a, input lsbod_pkg::range_t b,
                                  input lsbod_pkg::tol_t lo, input lsbod_pkg::tol_t hi);
    logic [lsbod_pkg::RANGE_W:0] a_lo;
    logic [lsbod_pkg::RANGE_W:0] b_hi;
    a_lo = {1'b0, a} + {{(lsbod_pkg::RANGE_W - lsbod_pkg::TOL_W + 1){1'b0}}, lo};
    b_hi = {1'b0, b} + {{(lsbod_pkg::RANGE_W - lsbod_pkg::TOL_W + 1){1'b0}}, hi};
    return !(a_lo < {1'b0, b}) && !({1'b0, a} > b_hi);
  endfunction

  assign adv      = !sum_valid || sum_ready;
  assign fire     = hold_valid && adv;
  assign in_ready = !hold_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold <= in_data;
    end
  end

  // beam m = beam_count-1 is judged now that its right neighbour has arrived
  assign counting = beam_count < lsbod_pkg::cnt_t'(lsbod_pkg::BEAM_COUNT);
  assign judged   = counting && (beam_count >= lsbod_pkg::cnt_t'(2));
  assign mid_idx  = lsbod_pkg::rom_idx_t'(beam_count - lsbod_pkg::cnt_t'(1));

  always_comb begin
    fwd        = lsbod_pkg::prod_t'(prev_sample) * lsbod_pkg::prod_t'(lsbod_pkg::SIN_ROM[mid_idx]);
    side       = lsbod_pkg::prod_t'(prev_sample) * lsbod_pkg::prod_t'(lsbod_pkg::COS_ROM[mid_idx]);
    len_lim    = lsbod_pkg::prod_t'(cfg.box_length_mm) << lsbod_pkg::TRIG_FRACTION_BITS;
    wid_lim    = lsbod_pkg::prod_t'(cfg.box_width_mm) << lsbod_pkg::TRIG_FRACTION_BITS;
    box_hit    = (fwd < len_lim) && (side < wid_lim);
    agree_back = agrees(prev_sample, prev_prev_sample,
                        cfg.lower_tolerance_mm, cfg.upper_tolerance_mm);
    agree_fwd  = agrees(prev_sample, hold.range_mm,
                        cfg.lower_tolerance_mm, cfg.upper_tolerance_mm);

    best_range_next = best_range;
    best_angle_next = best_angle;
    // strict less-than: the first beam keeps a tie
    if (judged && (prev_sample < best_range)) begin
      best_range_next = prev_sample;
      best_angle_next = lsbod_pkg::angle_t'(mid_idx);
    end
    hit_flag_next = hit_flag || (judged && box_hit && agree_back && agree_fwd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_count       <= '0;
      prev_sample      <= '0;
      prev_prev_sample <= '0;
      best_range       <= lsbod_pkg::NO_HIT_RANGE;
      best_angle       <= '0;
      hit_flag         <= 1'b0;
    end else if (fire) begin
      if (hold.scan_end) begin
        beam_count       <= '0;
        prev_sample      <= '0;
        prev_prev_sample <= '0;
        best_range       <= lsbod_pkg::NO_HIT_RANGE;
        best_angle       <= '0;
        hit_flag         <= 1'b0;
      end else if (counting) begin
        beam_count       <= beam_count + lsbod_pkg::cnt_t'(1);
        prev_sample      <= hold.range_mm;
        prev_prev_sample <= prev_sample;
        best_range       <= best_range_next;
        best_angle       <= best_angle_next;
        hit_flag         <= hit_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (adv) begin
      sum_valid <= hold_valid && hold.scan_end;
    end
    if (fire) begin
      sum_data.best_range <= best_range_next;
      sum_data.best_angle <= best_angle_next;
      sum_data.hit        <= hit_flag_next;
    end
  end

  a_scan_clear: assert property (@(posedge clk) disable iff (rst)
    fire && hold.scan_end |=> beam_count == '0 && best_range == lsbod_pkg::NO_HIT_RANGE
                              && !hit_flag)
    else $error("scan state not cleared after scan end");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    beam_count <= lsbod_pkg::cnt_t'(lsbod_pkg::BEAM_COUNT))
    else $error("beam counter past saturation");

  a_best_sane: assert property (@(posedge clk) disable iff (rst)
    best_angle != '0 |-> best_range < lsbod_pkg::NO_HIT_RANGE
      && lsbod_pkg::cnt_t'(best_angle) <= lsbod_pkg::cnt_t'(lsbod_pkg::BEAM_COUNT - 2))
    else $error("nearest beam outside the judged range");

  a_sum_only_on_end: assert property (@(posedge clk) disable iff (rst)
    fire && !hold.scan_end |=> !sum_valid)
    else $error("summary raised without scan end");

endmodule

// ===== rtl/core/lsbod_ahead.sv =====
`timescale 1ns / 1ps
module lsbod_ahead (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sum_valid,
  output logic                 sum_ready,
  input  lsbod_pkg::scan_sum_t sum_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lsbod_pkg::out_word_t out_data
);

  logic                in_rom;
  lsbod_pkg::rom_idx_t idx;
  lsbod_pkg::prod_t    prod;
  lsbod_pkg::range_t   ahead;

  assign sum_ready = !out_valid || out_ready;

  always_comb begin
    in_rom = lsbod_pkg::cnt_t'(sum_data.best_angle) < lsbod_pkg::cnt_t'(lsbod_pkg::BEAM_COUNT);
    idx    = lsbod_pkg::rom_idx_t'(sum_data.best_angle);
    prod   = lsbod_pkg::prod_t'(sum_data.best_range) * lsbod_pkg::prod_t'(lsbod_pkg::SIN_ROM[idx]);
    ahead  = in_rom ? lsbod_pkg::range_t'(prod >> lsbod_pkg::TRIG_FRACTION_BITS) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sum_ready) begin
      out_valid <= sum_valid;
    end
    if (sum_ready && sum_valid) begin
      out_data.nearest_range_mm  <= sum_data.best_range;
      out_data.nearest_angle_deg <= sum_data.best_angle;
      out_data.ahead_distance_mm <= ahead;
      out_data.obstacle          <= sum_data.hit;
    end
  end

endmodule

// ===== rtl/core/laser_scan_box_obstacle_detect_top.sv =====
`timescale 1ns / 1ps
// Laser scan box obstacle detector.
// in:  one range sample (mm) per word, valid/ready; sample k of a scan is the beam at
//      k degrees, scan_end marks the last sample of the scan.
// out: one word per scan, valid/ready: nearest range and angle over beams 1..178,
//      nearest range times sin(angle), and the obstacle flag.
// cfg: write-only registers (box length, box width, lower and upper tolerance), written
//      with cfg_wr_en/cfg_index/cfg_data while no scan is in flight.
// Throughput: one sample per clock while the output keeps up. The input register, the
// judging stage (table lookup, two range-by-trig multiplies and the box compare) and
// the output stage each hold one word, so the block keeps taking samples while a
// result waits. A scan's result passes from the input register through the judging
// stage's summary register to the output register (the second multiply, for the
// ahead distance, sits in the output stage).
// When out_ready is low the result holds and, once the stages fill, in_ready drops.
// Reset: registers return to their defaults, the scan state is cleared (nearest range
// 999999, no hit) and both channels are empty. No clearing pass is needed.
module laser_scan_box_obstacle_detect_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lsbod_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lsbod_pkg::out_word_t out_data,
  input  logic                 cfg_wr_en,
  input  lsbod_pkg::cfg_reg_e  cfg_index,
  input  lsbod_pkg::cfg_data_t cfg_data
);

  lsbod_pkg::cfg_t      cfg;
  logic                 sum_valid;
  logic                 sum_ready;
  lsbod_pkg::scan_sum_t sum_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_length_mm      <= 20'd1000;
      cfg.box_width_mm       <= 20'd500;
      cfg.lower_tolerance_mm <= 16'd500;
      cfg.upper_tolerance_mm <= 16'd50;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lsbod_pkg::REG_BOX_LENGTH: cfg.box_length_mm      <= cfg_data;
        lsbod_pkg::REG_BOX_WIDTH:  cfg.box_width_mm       <= cfg_data;
        lsbod_pkg::REG_LOWER_TOL:  cfg.lower_tolerance_mm <= cfg_data[lsbod_pkg::TOL_W-1:0];
        lsbod_pkg::REG_UPPER_TOL:  cfg.upper_tolerance_mm <= cfg_data[lsbod_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  lsbod_judge u_judge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data)
  );

  lsbod_ahead u_ahead (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
